>>> rtl/core/f3216_pkg.sv
// ----------------------------------------------------------------------------
// f3216_pkg
// shared op codes for the single/half converter
// ----------------------------------------------------------------------------
package f3216_pkg;

  typedef enum logic {
    OP_S2H = 1'b0,
    OP_H2S = 1'b1
  } op_t;

endpackage

>>> rtl/core/fp32_fp16_format_converter_core.sv
// ----------------------------------------------------------------------------
// fp32_fp16_format_converter_core
// binary32 <-> binary16 bit-pattern converter, one word per stall-free cycle
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid/in_ready with in_op, in_single_bits, in_half_bits
//   in_op selects single to half (half result in out_result_bits[15:0], upper
//   bits zero) or half to single; the field not selected is ignored
//   output channel: out_valid/out_ready with out_result_bits
// timing: an accepted input beat is a valid output beat in the next cycle
// throughput: one beat per cycle unless stalled; the conversion is a single
//   combinational pass between the input handshake and the result register
// stall: the result register holds while out_ready is low; in_ready stays
//   high as long as the result register is empty or is being drained, so
//   a stalled receiver holds the input for as long as the stall lasts
// rounding: single to half adds the guard bit (ties away from zero), and a
//   carry may reach inf; nan inputs give the quiet nan with mantissa 0x200
// reset: rst_n (synchronous, active low) empties the result register
// ----------------------------------------------------------------------------
module fp32_fp16_format_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [31:0] in_single_bits,
  input  logic [15:0] in_half_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_bits
);
  import f3216_pkg::*;

  logic        valid_r, valid_nxt;
  logic [31:0] res_r, res_nxt;
  logic        in_fire;

  // single to half
  logic        s_sign;
  logic [7:0]  s_exp;
  logic [22:0] s_man;
  logic [23:0] s_full;
  logic [23:0] s_shift;
  logic [3:0]  s_amt;
  logic [11:0] s_sub;
  logic [15:0] s_norm;
  logic [15:0] s2h;

  // half to single
  logic        h_sign;
  logic [4:0]  h_exp;
  logic [9:0]  h_man;
  logic [3:0]  h_lz;
  logic [9:0]  h_nman;
  logic [7:0]  h_nexp;
  logic [31:0] h2s;

  always_comb begin
    s_sign  = in_single_bits[31];
    s_exp   = in_single_bits[30:23];
    s_man   = in_single_bits[22:0];
    s_full  = {1'b1, s_man};
    // subnormal shift 1 - e with e = exp - 112, only used for exp in 102..112
    s_amt   = 4'(8'd113 - s_exp);
    s_shift = s_full >> s_amt;
    s_sub   = 12'(({1'b0, s_shift[23:13]} + {11'd0, s_shift[12]}));
    s_norm  = {s_sign, 5'(s_exp - 8'd112), s_man[22:13]} + {15'd0, s_man[12]};
    priority if (s_exp == 8'hFF) begin
      s2h = {s_sign, 5'h1F, (s_man != '0), 9'd0};
    end else if (s_exp >= 8'd143) begin
      s2h = {s_sign, 5'h1F, 10'd0};
    end else if (s_exp < 8'd102) begin
      s2h = {s_sign, 15'd0};
    end else if (s_exp <= 8'd112) begin
      s2h = {s_sign, 3'd0, s_sub};
    end else begin
      s2h = s_norm;
    end
  end

  always_comb begin
    h_sign = in_half_bits[15];
    h_exp  = in_half_bits[14:10];
    h_man  = in_half_bits[9:0];
    h_lz   = 4'd9;
    for (int i = 0; i < 10; i++) begin
      if (h_man[i]) h_lz = 4'(9 - i);
    end
    h_nman = 10'(h_man << (h_lz + 4'd1));
    h_nexp = 8'd112 - {4'd0, h_lz};
    priority if (h_exp == 5'd0 && h_man == '0) begin
      h2s = {h_sign, 31'd0};
    end else if (h_exp == 5'd0) begin
      h2s = {h_sign, h_nexp, h_nman, 13'd0};
    end else if (h_exp == 5'h1F) begin
      h2s = {h_sign, 8'hFF, h_man, 13'd0};
    end else begin
      h2s = {h_sign, {3'd0, h_exp} + 8'd112, h_man, 13'd0};
    end
  end

  assign in_ready = !valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (out_ready) valid_nxt = 1'b0;
    if (in_fire) begin
      valid_nxt = 1'b1;
      unique case (op_t'(in_op))
        OP_S2H:  res_nxt = {16'd0, s2h};
        OP_H2S:  res_nxt = h2s;
        default: res_nxt = h2s;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_valid       = valid_r;
  assign out_result_bits = res_r;

  // an accepted beat shows up at the output the next cycle
  a_fire_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid) else $error("accepted beat lost");
  // a stalled result is held
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_bits))
    else $error("stalled result changed");
  // half results keep the upper word clear
  a_s2h_upper: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_op == OP_S2H |=> out_result_bits[31:16] == 16'd0)
    else $error("half result upper bits set");
  // input never blocked while output drains
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready) else $error("input blocked while draining");

endmodule

>>> tb/sv/fp32_fp16_format_converter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp32_fp16_format_converter_core_test
// checks both conversion directions beat by beat against a local predictor,
// with directed corner words, random words and random gaps on both channels
// ----------------------------------------------------------------------------
module fp32_fp16_format_converter_core_test;
  import f3216_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    op_t         op;
    logic [31:0] single_bits;
    logic [15:0] half_bits;
  } word_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = 1'b0;
  logic [31:0] in_single_bits = '0;
  logic [15:0] in_half_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_result_bits;

  word_beat_t  pending_words[$];
  logic [31:0] expected_words[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          send_gap = 0;
  int          stall_left = 0;

  fp32_fp16_format_converter_core dut (.*);

  always #2 clk = ~clk;

  // single to half, guard bit added, no sticky bit
  function automatic logic [31:0] narrow_to_half(logic [31:0] x);
    logic [15:0] sgn;
    logic [7:0]  ebits;
    logic [23:0] man;
    int          e;
    logic [31:0] r;
    sgn = {x[31], 15'b0};
    ebits = x[30:23];
    man = {1'b0, x[22:0]};
    e = int'(ebits) - 112;
    if (ebits == 8'hFF) return {16'b0, sgn | 16'h7C00 | (x[22:0] != 0 ? 16'h0200 : 16'h0)};
    if (e >= 31) return {16'b0, sgn | 16'h7C00};
    if (e <= 0) begin
      if (e < -10) return {16'b0, sgn};
      man = {1'b1, x[22:0]} >> (1 - e);
      r = (32'(man) + 32'h1000) >> 13;
      return {16'b0, sgn | r[15:0]};
    end
    r = {16'b0, sgn} | (32'(e) << 10) | (32'(x[22:0]) >> 13);
    if (x[12]) r = r + 1;
    return r & 32'hFFFF;
  endfunction

  // half to single, exact
  function automatic logic [31:0] widen_to_single(logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  e;
    logic [10:0] man;
    int          shift;
    sgn = {h[15], 31'b0};
    e = h[14:10];
    man = {1'b0, h[9:0]};
    if (e == 0) begin
      if (man == 0) return sgn;
      shift = 0;
      while (!man[10]) begin
        man = man << 1;
        shift++;
      end
      return sgn | (32'(113 - shift) << 23) | (32'(man[9:0]) << 13);
    end
    if (e == 5'h1F) return sgn | 32'h7F800000 | (32'(man[9:0]) << 13);
    return sgn | (32'(e + 112) << 23) | (32'(man[9:0]) << 13);
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic queue_word(op_t op, logic [31:0] s, logic [15:0] h);
    word_beat_t w;
    w.op = op;
    w.single_bits = s;
    w.half_bits = h;
    pending_words = {pending_words, w};
  endtask

  // random single words biased toward the exponent window near half range
  function automatic logic [31:0] rand_single();
    logic [31:0] x;
    x = $urandom;
    if ($urandom_range(0, 3) != 0) x[30:23] = 8'($urandom_range(95, 146));
    if ($urandom_range(0, 9) == 0) x[12:0] = 13'h1000;
    return x;
  endfunction

  initial begin
    // directed corners
    queue_word(OP_S2H, 32'h0000_0000, 16'hFFFF);
    queue_word(OP_S2H, 32'h8000_0000, 16'h0000);
    queue_word(OP_S2H, 32'h7F80_0000, 16'h1234);
    queue_word(OP_S2H, 32'hFF80_0000, 16'h0);
    queue_word(OP_S2H, 32'h7FC0_0001, 16'h0);
    queue_word(OP_S2H, 32'hFFFF_FFFF, 16'h0);
    queue_word(OP_S2H, 32'h4780_0000, 16'h0);  // overflow to inf
    queue_word(OP_S2H, 32'h477F_F000, 16'h0);  // carry reaches inf
    queue_word(OP_S2H, 32'h3F80_1000, 16'h0);  // tie rounds up
    queue_word(OP_S2H, 32'h3380_0000, 16'h0);  // smallest half subnormal
    queue_word(OP_S2H, 32'h3300_0000, 16'h0);  // below subnormal range
    queue_word(OP_S2H, 32'h387F_F000, 16'h0);  // subnormal rounds to normal
    queue_word(OP_S2H, 32'h0000_0001, 16'h0);  // single subnormal
    queue_word(OP_S2H, 32'h3F80_0000, 16'h0);
    queue_word(OP_H2S, 32'hFFFF_FFFF, 16'h0000);
    queue_word(OP_H2S, 32'h0, 16'h8000);
    queue_word(OP_H2S, 32'h0, 16'h0001);
    queue_word(OP_H2S, 32'h0, 16'h03FF);
    queue_word(OP_H2S, 32'h0, 16'h8200);
    queue_word(OP_H2S, 32'h0, 16'h7C00);
    queue_word(OP_H2S, 32'h0, 16'hFFFF);
    queue_word(OP_H2S, 32'h0, 16'h7BFF);
    queue_word(OP_H2S, 32'h0, 16'h3C00);
    for (int i = 0; i < 1280; i++) begin
      if ($urandom_range(0, 1) == 0) queue_word(OP_S2H, rand_single(), 16'($urandom));
      else queue_word(OP_H2S, $urandom, 16'($urandom));
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_words.size() == 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // driver: holds each beat until accepted, random gaps between beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_words = {expected_words, (in_op ? widen_to_single(in_half_bits)
                                                 : narrow_to_half(in_single_bits))};
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0 || pending_words.size() == 0) begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end else begin
          in_valid <= 1'b1;
          in_op <= pending_words[0].op;
          in_single_bits <= pending_words[0].single_bits;
          in_half_bits <= pending_words[0].half_bits;
          void'(pending_words.pop_front());
          send_gap <= pick_gap();
        end
      end
    end
  end

  // monitor: checks each result beat, random receiver stalls
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time,
                   out_result_bits);
          fail_count <= fail_count + 1;
        end else begin
          if (out_result_bits !== expected_words[0]) begin
            $display("%0t: result_bits mismatch, expected %h, actual %h", $time,
                     expected_words[0], out_result_bits);
            fail_count <= fail_count + 1;
          end
          void'(expected_words.pop_front());
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
    end
  end

endmodule

>>> files.f
rtl/core/f3216_pkg.sv
rtl/core/fp32_fp16_format_converter_core.sv
tb/sv/fp32_fp16_format_converter_core_test.sv
